[hdl/lfia_pkg.sv]
// Package for the lowest free ID allocator.
// Holds the request mode codes, the word operation codes and the structs
// passed between the sequencer and the word update unit. No dependencies.
package lfia_pkg;

    localparam int WORD_W = 32;
    localparam int OFF_W  = 5;

    typedef enum logic [2:0] {
        MODE_ALLOC       = 3'd0,
        MODE_RELEASE     = 3'd1,
        MODE_MARK        = 3'd2,
        MODE_MARK_RANGE  = 3'd3,
        MODE_ALLOC_RANGE = 3'd4
    } mode_t;

    // OP_FIRST claims the lowest free bit, OP_CLAIM claims every bit up to
    // the first used one, OP_SET frees the bits of the mask.
    typedef enum logic [1:0] {
        OP_FIRST = 2'd0,
        OP_CLAIM = 2'd1,
        OP_SET   = 2'd2
    } op_t;

    typedef struct packed {
        op_t              op;
        logic             at_first;
        logic             at_last;
        logic [OFF_W-1:0] lo_off;
        logic [OFF_W-1:0] last_off;
    } word_req_t;

    typedef struct packed {
        logic              found;
        logic [OFF_W-1:0]  pos;
        logic [WORD_W-1:0] wdata;
    } word_rsp_t;

endpackage

[hdl/lfia_if.sv]
// Channel interfaces of the lowest free ID allocator: request and result.
// Valid/ready handshake; depends on nothing else.
interface lfia_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [7:0] id;
    logic [8:0] range_end;

    modport source (output valid, mode, id, range_end, input ready);
    modport sink (input valid, mode, id, range_end, output ready);
endinterface

interface lfia_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] result_id;
    logic       ok;

    modport source (output valid, result_id, ok, input ready);
    modport sink (input valid, result_id, ok, output ready);
endinterface

[hdl/lfia_ram.sv]
// Single-port-write, single-port-read synchronous RAM holding the free
// bitmap, one 32-bit word per entry, with registered read data.
// Depends on lfia_pkg for the word width.
module lfia_ram
    import lfia_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int AW    = 3
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/lfia_word_op.sv]
// Word update unit: builds the range mask for one bitmap word, finds the
// lowest free or used bit inside it and forms the word to write back.
// Depends on lfia_pkg.
module lfia_word_op
    import lfia_pkg::*;
(
    input  logic [WORD_W-1:0] data,
    input  word_req_t         req,
    output word_rsp_t         rsp
);

    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] cand;
    logic [WORD_W-1:0] iso;
    logic [WORD_W-1:0] below;
    logic [OFF_W-1:0]  pos;

    always_comb
    begin
        mask = '0;
        for (int j = 0; j < WORD_W; j++)
        begin
            mask[j] = (!req.at_first || (OFF_W'(j) >= req.lo_off)) &&
                      (!req.at_last  || (OFF_W'(j) <= req.last_off));
        end
        cand = (req.op == OP_CLAIM) ? (~data & mask) : (data & mask);
        // Isolate the lowest set bit; the bits below it form iso - 1, which
        // is all ones when nothing is set.
        iso   = cand & (~cand + WORD_W'(1));
        below = iso - WORD_W'(1);
        pos   = '0;
        for (int j = 0; j < WORD_W; j++)
        begin
            if (iso[j])
            begin
                pos = pos | OFF_W'(j);
            end
        end
        rsp.found = |cand;
        rsp.pos   = pos;
        unique case (req.op)
            OP_FIRST: rsp.wdata = data & ~iso;
            OP_CLAIM: rsp.wdata = data & ~(mask & below);
            OP_SET:   rsp.wdata = data | mask;
            default:  rsp.wdata = data;
        endcase
    end

endmodule

[hdl/lowest_free_id_allocator_top.sv]
// Lowest free ID allocator: one free bit per ID kept in a RAM of 32-bit
// words, ID 0 never free. A request that touches a single word (release,
// mark used, and allocations or ranges that end in their first word) passes
// a RAM read state, an update state and a finishing state before the next
// is accepted; every further word scanned adds one RAM read and one
// read-modify-write, and a plain allocate scans at most ceil(ID_COUNT / 32)
// words. A request with an empty range goes straight to the finishing
// state. After reset a clearing pass writes each RAM word before the first
// item is taken. Depends on lfia_pkg, lfia_if, lfia_ram and lfia_word_op.
module lowest_free_id_allocator_top
    import lfia_pkg::*;
#(
    parameter int ID_COUNT = 256
)
(
    input  logic      clk,
    input  logic      rst_n,
    lfia_req_if.sink  req,
    lfia_rsp_if.source rsp
);

    localparam int AW    = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
    localparam int PW    = (AW + 1 > 9) ? AW + 1 : 9;
    localparam int CW    = PW - OFF_W;
    localparam int DEPTH = (ID_COUNT + WORD_W - 1) / WORD_W;
    localparam int WAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [WAW-1:0] LAST_WORD = WAW'(DEPTH - 1);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_RD,
        ST_PROC,
        ST_FIN
    } state_t;

    state_t           state_reg;
    logic [WAW-1:0]   init_cnt_reg;
    op_t              op_reg;
    logic             ovf_reg;
    logic [CW-1:0]    cur_w_reg;
    logic [CW-1:0]    lo_w_reg;
    logic [OFF_W-1:0] lo_off_reg;
    logic [CW-1:0]    last_w_reg;
    logic [OFF_W-1:0] last_off_reg;
    logic [7:0]       res_id_reg;
    logic             res_ok_reg;
    logic             out_valid_reg;
    logic [7:0]       out_id_reg;
    logic             out_ok_reg;

    logic [PW-1:0] id_p;
    logic [PW-1:0] end_p;
    logic [PW-1:0] cnt_p;
    logic [PW-1:0] end_clip;
    logic [PW-1:0] lo_next;
    logic [PW-1:0] hi_next;
    logic [PW-1:0] last_next;
    op_t           op_next;
    logic          ovf_next;
    logic          empty_ok;

    logic              ram_we;
    logic [WAW-1:0]    ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] init_word;
    word_req_t         wreq;
    word_rsp_t         wrsp;
    logic [PW-1:0]     found_id;

    // Request decode into an ID range [lo, hi) and a word operation.
    always_comb
    begin
        id_p     = PW'(req.id);
        end_p    = PW'(req.range_end);
        cnt_p    = PW'(ID_COUNT);
        end_clip = (end_p < cnt_p) ? end_p : cnt_p;
        lo_next  = id_p;
        hi_next  = end_clip;
        op_next  = OP_FIRST;
        ovf_next = 1'b0;
        unique case (mode_t'(req.mode))
            MODE_ALLOC:
            begin
                lo_next = PW'(1);
                hi_next = cnt_p;
            end
            MODE_RELEASE:
            begin
                op_next = OP_SET;
                hi_next = ((id_p != '0) && (id_p < cnt_p)) ? id_p + PW'(1) : id_p;
            end
            MODE_MARK:
            begin
                op_next  = OP_CLAIM;
                hi_next  = (id_p < cnt_p) ? id_p + PW'(1) : id_p;
                ovf_next = (id_p >= cnt_p);
            end
            MODE_MARK_RANGE:
            begin
                op_next  = OP_CLAIM;
                ovf_next = (end_p > cnt_p) && (id_p < end_p);
            end
            MODE_ALLOC_RANGE:
            begin
                op_next = OP_FIRST;
            end
            default:
            begin
                lo_next = '0;
                hi_next = '0;
            end
        endcase
        last_next = hi_next - PW'(1);
        unique case (op_next)
            OP_FIRST: empty_ok = 1'b0;
            OP_CLAIM: empty_ok = !ovf_next;
            OP_SET:   empty_ok = 1'b1;
            default:  empty_ok = 1'b0;
        endcase
    end

    // Reset image of one word: a bit is free when its ID lies in 1..ID_COUNT-1.
    always_comb
    begin
        init_word = '0;
        for (int j = 0; j < WORD_W; j++)
        begin
            init_word[j] = (32'({init_cnt_reg, OFF_W'(j)}) < 32'(ID_COUNT)) &&
                           ({init_cnt_reg, OFF_W'(j)} != '0);
        end
    end

    always_comb
    begin
        wreq.op       = op_reg;
        wreq.at_first = (cur_w_reg == lo_w_reg);
        wreq.at_last  = (cur_w_reg == last_w_reg);
        wreq.lo_off   = lo_off_reg;
        wreq.last_off = last_off_reg;
        found_id      = {cur_w_reg, wrsp.pos};
    end

    // The RAM is written only in the clearing pass and in the update cycle,
    // and the next read of the same word is never issued before that write.
    assign ram_we    = (state_reg == ST_INIT) || (state_reg == ST_PROC);
    assign ram_waddr = (state_reg == ST_INIT) ? init_cnt_reg : cur_w_reg[WAW-1:0];
    assign ram_wdata = (state_reg == ST_INIT) ? init_word : wrsp.wdata;

    lfia_ram #(
        .DEPTH (DEPTH),
        .AW    (WAW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cur_w_reg[WAW-1:0]),
        .rdata (ram_rdata)
    );

    lfia_word_op u_word_op (
        .data (ram_rdata),
        .req  (wreq),
        .rsp  (wrsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            init_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            op_reg        <= OP_FIRST;
            ovf_reg       <= 1'b0;
            cur_w_reg     <= '0;
            lo_w_reg      <= '0;
            lo_off_reg    <= '0;
            last_w_reg    <= '0;
            last_off_reg  <= '0;
            res_id_reg    <= '0;
            res_ok_reg    <= 1'b0;
            out_id_reg    <= '0;
            out_ok_reg    <= 1'b0;
        end
        else
        begin
            // In the finishing state the result register is reloaded below instead.
            if (out_valid_reg && rsp.ready && (state_reg != ST_FIN))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_INIT:
                begin
                    init_cnt_reg <= init_cnt_reg + WAW'(1);
                    if (init_cnt_reg == LAST_WORD)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_reg       <= op_next;
                        ovf_reg      <= ovf_next;
                        cur_w_reg    <= lo_next[PW-1:OFF_W];
                        lo_w_reg     <= lo_next[PW-1:OFF_W];
                        lo_off_reg   <= lo_next[OFF_W-1:0];
                        last_w_reg   <= last_next[PW-1:OFF_W];
                        last_off_reg <= last_next[OFF_W-1:0];
                        if (lo_next >= hi_next)
                        begin
                            res_id_reg <= '0;
                            res_ok_reg <= empty_ok;
                            state_reg  <= ST_FIN;
                        end
                        else
                        begin
                            state_reg <= ST_RD;
                        end
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_PROC;
                end
                ST_PROC:
                begin
                    unique case (op_reg)
                        OP_FIRST:
                        begin
                            if (wrsp.found)
                            begin
                                res_id_reg <= found_id[7:0];
                                res_ok_reg <= 1'b1;
                                state_reg  <= ST_FIN;
                            end
                            else if (wreq.at_last)
                            begin
                                res_id_reg <= '0;
                                res_ok_reg <= 1'b0;
                                state_reg  <= ST_FIN;
                            end
                            else
                            begin
                                cur_w_reg <= cur_w_reg + CW'(1);
                                state_reg <= ST_RD;
                            end
                        end
                        OP_CLAIM:
                        begin
                            res_id_reg <= '0;
                            if (wrsp.found)
                            begin
                                res_ok_reg <= 1'b0;
                                state_reg  <= ST_FIN;
                            end
                            else if (wreq.at_last)
                            begin
                                res_ok_reg <= !ovf_reg;
                                state_reg  <= ST_FIN;
                            end
                            else
                            begin
                                cur_w_reg <= cur_w_reg + CW'(1);
                                state_reg <= ST_RD;
                            end
                        end
                        OP_SET:
                        begin
                            res_id_reg <= '0;
                            res_ok_reg <= 1'b1;
                            state_reg  <= ST_FIN;
                        end
                        default:
                        begin
                            res_id_reg <= '0;
                            res_ok_reg <= 1'b0;
                            state_reg  <= ST_FIN;
                        end
                    endcase
                end
                ST_FIN:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_id_reg    <= res_id_reg;
                        out_ok_reg    <= res_ok_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign req.ready     = (state_reg == ST_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.result_id = out_id_reg;
    assign rsp.ok        = out_ok_reg;

endmodule

[hdl/lfia_checker.sv]
// Port-level checks for the lowest free ID allocator, attached to the top
// level by the bind statement at the end. Depends on the top level only.
module lfia_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] result_id,
    input logic       ok
);

    // A result item that is offered stays offered until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item withdrawn before it was taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(result_id) && $stable(ok))
        else $error("stalled result item changed");

    // One item at a time: after an item is taken the block is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted while one is in progress");

    // A new result is never raised straight after the block was ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result item produced without an item in progress");

    // An allocated ID is only reported with success.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_id != 8'd0) |-> ok)
        else $error("nonzero ID reported with failure");

endmodule

bind lowest_free_id_allocator_top lfia_checker u_lfia_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .result_id (rsp.result_id),
    .ok        (rsp.ok)
);

[bench/lowest_free_id_allocator_top_test.sv]
`timescale 1ns / 100ps
// Self-checking bench for the lowest free ID allocator: directed and random requests of
// every mode, each result checked against a free-map predictor kept in a scoreboard class.
// Depends on lfia_pkg, lfia_if and lowest_free_id_allocator_top.
module lowest_free_id_allocator_top_test;
    import lfia_pkg::*;

    localparam int POOL_SIZE    = 256;
    localparam int RANDOM_ITEMS = 1100;
    localparam int SETTLE_WAIT  = 40;
    localparam logic [2:0] MODE_SPARE_LO  = 3'd5;
    localparam logic [2:0] MODE_SPARE_MID = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI  = 3'd7;

    class id_pool_scoreboard;
        typedef struct packed {
            logic [7:0] result_id;
            logic       ok;
        } grant_t;

        bit [POOL_SIZE-1:0] free_ids;
        grant_t             awaited[$];
        int                 failures;
        int                 checked;
        int                 exhausted;
        int                 mode_counts[8];

        function new();
            free_ids    = '1;
            free_ids[0] = 1'b0;
            failures    = 0;
            checked     = 0;
            exhausted   = 0;
            foreach (mode_counts[i])
                mode_counts[i] = 0;
        endfunction

        function bit claim_id(int v);
            if (v <= 0 || v >= POOL_SIZE || !free_ids[v])
                return 1'b0;
            free_ids[v] = 1'b0;
            return 1'b1;
        endfunction

        function void note_request(logic [2:0] mode, logic [7:0] start, logic [8:0] stop);
            grant_t g;
            g = '0;
            mode_counts[mode]++;
            case (mode)
                MODE_ALLOC:
                begin
                    for (int v = 1; v < POOL_SIZE; v++)
                    begin
                        if (claim_id(v))
                        begin
                            g.result_id = v[7:0];
                            g.ok        = 1'b1;
                            break;
                        end
                    end
                    if (!g.ok)
                        exhausted++;
                end
                MODE_RELEASE:
                begin
                    if (start != 8'd0)
                        free_ids[start] = 1'b1;
                    g.ok = 1'b1;
                end
                MODE_MARK:
                    g.ok = claim_id(start);
                MODE_MARK_RANGE:
                begin
                    // Claims stop at the first ID that is not free; earlier claims stand.
                    g.ok = 1'b1;
                    for (int v = start; v < stop; v++)
                    begin
                        if (!claim_id(v))
                        begin
                            g.ok = 1'b0;
                            break;
                        end
                    end
                end
                MODE_ALLOC_RANGE:
                begin
                    for (int v = start; v < stop; v++)
                    begin
                        if (claim_id(v))
                        begin
                            g.result_id = v[7:0];
                            g.ok        = 1'b1;
                            break;
                        end
                    end
                end
                default:
                    g = '0;
            endcase
            awaited.push_back(g);
        endfunction

        function void report(string what);
            failures++;
            if (failures <= 10)
                $display("%0t mismatch: %s", $realtime, what);
        endfunction

        function void check_result(logic [7:0] result_id, logic ok);
            grant_t g;
            if (awaited.size() == 0)
            begin
                report($sformatf("unexpected result id %0d ok %0d", result_id, ok));
                return;
            end
            g = awaited.pop_front();
            checked++;
            if (result_id !== g.result_id)
                report($sformatf("result_id expected %0d got %0d", g.result_id, result_id));
            if (ok !== g.ok)
                report($sformatf("ok expected %0d got %0d", g.ok, ok));
        endfunction
    endclass

    bit   clk;
    logic rst_n;
    int   send_idle_pct;
    int   take_idle_pct;

    id_pool_scoreboard sb;

    lfia_req_if req_ch ();
    lfia_rsp_if rsp_ch ();

    lowest_free_id_allocator_top #(.ID_COUNT(POOL_SIZE)) dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        rsp_ch.ready <= rst_n && ($urandom_range(99) >= take_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.result_id, rsp_ch.ok);
    end

    // Presents one item from a falling edge and returns at the rising edge that accepts it.
    task automatic send_request(input logic [2:0] mode, input logic [7:0] start,
                                input logic [8:0] stop);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.mode      <= mode;
        req_ch.id        <= start;
        req_ch.range_end <= stop;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(mode, start, stop);
    endtask

    task automatic hold_until_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_id(bit want_free);
        int v;
        for (int i = 0; i < 16; i++)
        begin
            v = $urandom_range(POOL_SIZE - 1, 1);
            if (sb.free_ids[v] == want_free)
                return v[7:0];
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic run_directed();
        send_request(MODE_ALLOC, 8'd0, 9'd0);
        send_request(MODE_ALLOC, 8'd255, 9'd256);
        send_request(MODE_RELEASE, 8'd0, 9'd0);
        send_request(MODE_RELEASE, 8'd1, 9'd0);
        send_request(MODE_RELEASE, 8'd1, 9'd0);
        send_request(MODE_MARK, 8'd0, 9'd0);
        send_request(MODE_MARK, 8'd2, 9'd0);
        send_request(MODE_MARK, 8'd255, 9'd0);
        send_request(MODE_MARK_RANGE, 8'd10, 9'd10);
        send_request(MODE_MARK_RANGE, 8'd20, 9'd5);
        send_request(MODE_MARK_RANGE, 8'd5, 9'd9);
        send_request(MODE_MARK_RANGE, 8'd3, 9'd12);
        send_request(MODE_MARK_RANGE, 8'd0, 9'd4);
        send_request(MODE_MARK_RANGE, 8'd200, 9'd256);
        send_request(MODE_ALLOC_RANGE, 8'd200, 9'd256);
        send_request(MODE_ALLOC_RANGE, 8'd0, 9'd4);
        // Claim all that is left but ID 9; the allocate after it takes ID 9, so the pool runs dry.
        send_request(MODE_MARK_RANGE, 8'd10, 9'd200);
        send_request(MODE_ALLOC, 8'd0, 9'd0);
        send_request(MODE_ALLOC_RANGE, 8'd0, 9'd256);
        send_request(MODE_RELEASE, 8'd255, 9'd0);
        send_request(MODE_ALLOC, 8'd0, 9'd0);
        send_request(MODE_SPARE_LO, 8'd255, 9'd256);
        send_request(MODE_SPARE_MID, 8'd128, 9'd128);
        send_request(MODE_SPARE_HI, 8'd1, 9'd511);
        send_request(MODE_RELEASE, 8'd128, 9'd256);
    endtask

    // bias 0 favours claiming, 2 favours releasing, so the pool both fills and drains.
    task automatic random_request(input int bias);
        int         r;
        int         rel_pct;
        int         span;
        int         top;
        logic [7:0] start;
        logic [8:0] stop;
        rel_pct = (bias == 0) ? 10 : ((bias == 1) ? 28 : 50);
        r       = $urandom_range(99);
        if (r < rel_pct)
        begin
            start = ($urandom_range(9) < 8) ? pick_id(1'b0) : 8'($urandom_range(255));
            send_request(MODE_RELEASE, start, 9'($urandom_range(256)));
            return;
        end
        r = $urandom_range(99);
        if (r < 35)
            send_request(MODE_ALLOC, 8'($urandom_range(255)), 9'($urandom_range(256)));
        else if (r < 52)
        begin
            start = $urandom_range(1) ? pick_id(1'b1) : 8'($urandom_range(255));
            send_request(MODE_MARK, start, 9'($urandom_range(256)));
        end
        else if (r < 94)
        begin
            start = ($urandom_range(2) != 0) ? pick_id(1'b1) : 8'($urandom_range(255));
            span  = $urandom_range(9);
            case ($urandom_range(9))
                0:       stop = 9'($urandom_range(256));
                1:       stop = 9'd256;
                default:
                begin
                    top  = int'(start) + span;
                    stop = (top > POOL_SIZE) ? 9'd256 : 9'(top);
                end
            endcase
            send_request((r < 67) ? MODE_MARK_RANGE : MODE_ALLOC_RANGE, start, stop);
        end
        else
            send_request(3'($urandom_range(MODE_SPARE_HI, MODE_SPARE_LO)),
                         8'($urandom_range(255)), 9'($urandom_range(256)));
    endtask

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int bias;
        sb               = new();
        send_idle_pct    = 7;
        take_idle_pct    = 74;
        bias             = 1;
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.mode      = MODE_ALLOC;
        req_ch.id        = 8'd0;
        req_ch.range_end = 9'd0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 7 : ((phase == 1) ? 74 : 0);
            take_idle_pct = (phase == 0) ? 74 : ((phase == 1) ? 7 : 0);
            for (int n = 0; n < RANDOM_ITEMS / 3; n++)
            begin
                if (n % 64 == 0)
                    bias = $urandom_range(2);
                random_request(bias);
            end
            // The sender holds off here until every outstanding result is back.
            hold_until_drained();
        end
        repeat (SETTLE_WAIT) @(posedge clk);

        $display("Sent %0d allocate, %0d release, %0d mark, %0d range mark, %0d range allocate",
                 sb.mode_counts[MODE_ALLOC], sb.mode_counts[MODE_RELEASE],
                 sb.mode_counts[MODE_MARK], sb.mode_counts[MODE_MARK_RANGE],
                 sb.mode_counts[MODE_ALLOC_RANGE]);
        $display("requests; %0d results checked, %0d allocations met an empty pool, %0d failures.",
                 sb.checked, sb.exhausted, sb.failures);
        if (sb.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
